// ----- design/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg: shared types and codes of the task scheduler
// Sequencer states, mode and register codes, the queued task record and the
// operation word that drives the queue cells.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam logic [1:0] MODE_FCFS = 2'd0;
  localparam logic [1:0] MODE_RR   = 2'd1;
  localparam logic [1:0] MODE_SJF  = 2'd2;
  localparam logic [1:0] MODE_PRIO = 2'd3;

  localparam logic FUNC_ADMIT = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_CPUS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_DISPATCH,
    ST_AGE
  } state_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] rem;
    logic [7:0]  rank;
    logic        started;
  } task_t;

  typedef struct packed {
    logic load;     // write the load record at the insert point
    logic sorted;   // insert point found by key, else the tail
    logic by_prio;  // key is rank, else remaining work
    logic pop;      // shift every entry one place toward the head
    logic age;      // advance wait or turnaround counters
    logic rr;       // round robin aging rule
  } q_op_t;

endpackage

// ----- design/mts_in_if.sv -----
// ----------------------------------------------------------------------------
// mts_in_if: input channel of the task scheduler
// Carries one admit or tick transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mts_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  task_id;
  logic [15:0] burst_length;
  logic [7:0]  task_priority;

  modport source (output valid, func, task_id, burst_length, task_priority, input ready);
  modport sink   (input valid, func, task_id, burst_length, task_priority, output ready);
endinterface

// ----- design/mts_out_if.sv -----
// ----------------------------------------------------------------------------
// mts_out_if: result channel of the task scheduler
// Carries one per-processor result transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cpu_index;
  logic        running_valid;
  logic [7:0]  running_id;
  logic        finished_valid;
  logic [7:0]  finished_id;
  logic [15:0] finished_wait;
  logic [15:0] finished_turnaround;
  logic        queue_overflow;
  logic        last;

  modport source (output valid, cpu_index, running_valid, running_id, finished_valid,
                  finished_id, finished_wait, finished_turnaround, queue_overflow, last,
                  input ready);
  modport sink   (input valid, cpu_index, running_valid, running_id, finished_valid,
                  finished_id, finished_wait, finished_turnaround, queue_overflow, last,
                  output ready);
endinterface

// ----- design/mts_queue_cell.sv -----
// ----------------------------------------------------------------------------
// mts_queue_cell: one entry of the ready queue
// Holds a task record and takes its neighbor's entry on insert or pop.
// ----------------------------------------------------------------------------
module mts_queue_cell #(
  parameter int IDX   = 0,
  parameter int CW    = 16,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  mts_pkg::q_op_t    op,
  input  logic [CNT_W-1:0]  count,
  input  mts_pkg::task_t    load_item,
  input  logic [CW-1:0]     load_wait,
  input  logic [CW-1:0]     load_turn,
  input  mts_pkg::task_t    left_item,
  input  logic [CW-1:0]     left_wait,
  input  logic [CW-1:0]     left_turn,
  input  mts_pkg::task_t    right_item,
  input  logic [CW-1:0]     right_wait,
  input  logic [CW-1:0]     right_turn,
  input  logic              ahead_in,
  output logic              ahead_out,
  output mts_pkg::task_t    item,
  output logic [CW-1:0]     wait_cnt,
  output logic [CW-1:0]     turn_cnt
);

  logic live;
  logic at_tail;
  logic gt;

  assign live    = CNT_W'(IDX) < count;
  assign at_tail = CNT_W'(IDX) == count;
  assign gt      = op.sorted && live &&
                   (op.by_prio ? (item.rank > load_item.rank) : (item.rem > load_item.rem));
  assign ahead_out = ahead_in | gt;

  always_ff @(posedge clk) begin
    if (op.load) begin
      if (!ahead_in && (gt || at_tail)) begin
        item     <= load_item;
        wait_cnt <= load_wait;
        turn_cnt <= load_turn;
      end else if (ahead_in && (live || at_tail)) begin
        item     <= left_item;
        wait_cnt <= left_wait;
        turn_cnt <= left_turn;
      end
    end else if (op.pop) begin
      item     <= right_item;
      wait_cnt <= right_wait;
      turn_cnt <= right_turn;
    end else if (op.age && live) begin
      if (op.rr && item.started) begin
        if (turn_cnt != '1) turn_cnt <= turn_cnt + 1'b1;
      end else begin
        if (wait_cnt != '1) wait_cnt <= wait_cnt + 1'b1;
      end
    end
  end

endmodule

// ----- design/mts_queue.sv -----
// ----------------------------------------------------------------------------
// mts_queue: ready queue as a row of cells
// Sorted or tail insert, head pop with shift, and in-place aging.
// ----------------------------------------------------------------------------
module mts_queue #(
  parameter int QN    = 72,
  parameter int CW    = 16,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  mts_pkg::q_op_t    op,
  input  logic [CNT_W-1:0]  count,
  input  mts_pkg::task_t    load_item,
  input  logic [CW-1:0]     load_wait,
  input  logic [CW-1:0]     load_turn,
  output mts_pkg::task_t    head_item,
  output logic [CW-1:0]     head_wait,
  output logic [CW-1:0]     head_turn
);

  mts_pkg::task_t items [QN];
  logic [CW-1:0]  waits [QN];
  logic [CW-1:0]  turns [QN];
  logic           ahead [QN+1];

  assign ahead[0] = 1'b0;

  for (genvar g = 0; g < QN; g++) begin : g_cell
    localparam int L = (g == 0) ? 0 : g - 1;
    localparam int R = (g == QN - 1) ? g : g + 1;
    mts_queue_cell #(.IDX(g), .CW(CW), .CNT_W(CNT_W)) u_cell (
      .clk        (clk),
      .op         (op),
      .count      (count),
      .load_item  (load_item),
      .load_wait  (load_wait),
      .load_turn  (load_turn),
      .left_item  (items[L]),
      .left_wait  (waits[L]),
      .left_turn  (turns[L]),
      .right_item (items[R]),
      .right_wait (waits[R]),
      .right_turn (turns[R]),
      .ahead_in   (ahead[g]),
      .ahead_out  (ahead[g+1]),
      .item       (items[g]),
      .wait_cnt   (waits[g]),
      .turn_cnt   (turns[g])
    );
  end

  assign head_item = items[0];
  assign head_wait = waits[0];
  assign head_turn = turns[0];

endmodule

// ----- design/multiprocessor_task_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// multiprocessor_task_scheduler_unit: multiprocessor task scheduler
// Admits tasks into a queue of cells and steps processors once per tick.
// ----------------------------------------------------------------------------
// Admit: no result; admits can follow back to back.
// Tick: accept, retire pass, dispatch pass and aging step, in that order, for
//   N active processors; results are registered in the dispatch pass, which
//   holds while the result register is not taken.
// Reset: synchronous; queue empty, processors idle, overflow flag clear,
//   mode FCFS, one active processor.
module multiprocessor_task_scheduler_unit #(
  parameter int MAX_CPUS    = 8,
  parameter int QUEUE_DEPTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic       wr_index,
  input  logic [3:0] wr_data,
  mts_in_if.sink     in_item,
  mts_out_if.source  out_result
);

  localparam int NCPU  = (MAX_CPUS < 8) ? MAX_CPUS : 8;
  localparam int CPU_W = (NCPU > 1) ? $clog2(NCPU) : 1;
  localparam int QN    = QUEUE_DEPTH + NCPU;
  localparam int CNT_W = $clog2(QN + 1);
  localparam int CW    = COUNT_WIDTH;

  mts_pkg::state_t state, state_next;

  logic [1:0]       mode;
  logic [3:0]       active_cpus;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] q_count;
  logic             overflow_seen;
  logic [CPU_W-1:0] idx;
  logic [CPU_W-1:0] last_idx;
  logic [CPU_W-1:0] last_calc;
  logic             is_rr;

  logic             busy      [NCPU];
  mts_pkg::task_t   s_item    [NCPU];
  logic [CW-1:0]    s_wait    [NCPU];
  logic [CW-1:0]    s_turn    [NCPU];
  logic             f_valid   [NCPU];
  logic [7:0]       f_id      [NCPU];
  logic [15:0]      f_wait    [NCPU];
  logic [15:0]      f_tat     [NCPU];

  mts_pkg::q_op_t   q_op;
  mts_pkg::task_t   load_item;
  logic [CW-1:0]    load_wait;
  logic [CW-1:0]    load_turn;
  mts_pkg::task_t   head_item;
  mts_pkg::task_t   head_take;
  logic [CW-1:0]    head_wait;
  logic [CW-1:0]    head_turn;

  logic             in_fire;
  logic             admit_go;
  logic             tick_go;
  logic             retire_now;
  logic             still_busy;
  logic             out_free;
  logic             disp_go;
  logic             take_head;
  logic             pass_end;
  logic [32:0]      sum_wt;
  logic [15:0]      wait_clamp;
  logic [15:0]      tat_clamp;

  assign is_rr      = mode == mts_pkg::MODE_RR;
  assign in_fire    = in_item.valid && in_item.ready;
  assign admit_go   = in_fire && (in_item.func == mts_pkg::FUNC_ADMIT);
  assign tick_go    = in_fire && (in_item.func == mts_pkg::FUNC_TICK);
  assign retire_now = busy[idx] && (s_item[idx].rem == 16'd0);
  assign still_busy = busy[idx] && !retire_now;
  assign out_free   = !out_result.valid || out_result.ready;
  assign disp_go    = (state == mts_pkg::ST_DISPATCH) && out_free;
  assign take_head  = !busy[idx] && (count != '0);
  assign pass_end   = idx == last_idx;
  assign count_eff  = (count > CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : count;
  assign q_count    = (state == mts_pkg::ST_AGE) ? count_eff : count;

  assign sum_wt     = 33'(s_wait[idx]) + 33'(s_turn[idx]);
  assign wait_clamp = (33'(s_wait[idx]) > 33'h0FFFF) ? 16'hFFFF : 16'(s_wait[idx]);
  assign tat_clamp  = (sum_wt > 33'h0FFFF) ? 16'hFFFF : sum_wt[15:0];

  // round robin marks a dispatched task as started
  always_comb begin
    head_take         = head_item;
    head_take.started = head_item.started | is_rr;
  end

  // active count: zero acts as one, clip at the slot count
  always_comb begin
    logic [4:0] n;
    n = (active_cpus == 4'd0) ? 5'd1 : {1'b0, active_cpus};
    if (n > 5'(NCPU)) n = 5'(NCPU);
    last_calc = CPU_W'(n - 5'd1);
  end

  always_comb begin
    state_next = state;
    case (state)
      mts_pkg::ST_IDLE:     if (tick_go) state_next = mts_pkg::ST_RETIRE;
      mts_pkg::ST_RETIRE:   if (pass_end) state_next = mts_pkg::ST_DISPATCH;
      mts_pkg::ST_DISPATCH: if (disp_go && pass_end) state_next = mts_pkg::ST_AGE;
      mts_pkg::ST_AGE:      state_next = mts_pkg::ST_IDLE;
      default:              state_next = mts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_op      = '0;
    q_op.rr   = is_rr;
    load_item = s_item[idx];
    load_wait = s_wait[idx];
    load_turn = s_turn[idx];
    case (state)
      mts_pkg::ST_IDLE: begin
        load_item.task_id = in_item.task_id;
        load_item.rem     = in_item.burst_length;
        load_item.rank    = in_item.task_priority;
        load_item.started = 1'b0;
        load_wait         = '0;
        load_turn         = '0;
        q_op.load    = admit_go && (count < CNT_W'(QUEUE_DEPTH));
        q_op.sorted  = mode inside {mts_pkg::MODE_SJF, mts_pkg::MODE_PRIO};
        q_op.by_prio = mode == mts_pkg::MODE_PRIO;
      end
      mts_pkg::ST_RETIRE:   q_op.load = is_rr && still_busy;
      mts_pkg::ST_DISPATCH: q_op.pop  = disp_go && take_head;
      mts_pkg::ST_AGE:      q_op.age  = 1'b1;
      default:              q_op      = '0;
    endcase
  end

  mts_queue #(.QN(QN), .CW(CW), .CNT_W(CNT_W)) u_queue (
    .clk       (clk),
    .op        (q_op),
    .count     (q_count),
    .load_item (load_item),
    .load_wait (load_wait),
    .load_turn (load_turn),
    .head_item (head_item),
    .head_wait (head_wait),
    .head_turn (head_turn)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mts_pkg::ST_IDLE;
      mode          <= mts_pkg::MODE_FCFS;
      active_cpus   <= 4'd1;
      count         <= '0;
      overflow_seen <= 1'b0;
      idx           <= '0;
      last_idx      <= '0;
      out_result.valid <= 1'b0;
      for (int i = 0; i < NCPU; i++) busy[i] <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        if (wr_index == mts_pkg::REG_MODE) mode <= wr_data[1:0];
        else active_cpus <= wr_data;
      end
      if (disp_go) out_result.valid <= 1'b1;
      else if (out_result.valid && out_result.ready) out_result.valid <= 1'b0;
      case (state)
        mts_pkg::ST_IDLE: begin
          idx      <= '0;
          last_idx <= last_calc;
          if (admit_go) begin
            if (count >= CNT_W'(QUEUE_DEPTH)) overflow_seen <= 1'b1;
            else count <= count + 1'b1;
          end
        end
        mts_pkg::ST_RETIRE: begin
          f_valid[idx] <= retire_now;
          f_id[idx]    <= s_item[idx].task_id;
          f_wait[idx]  <= wait_clamp;
          f_tat[idx]   <= tat_clamp;
          // round robin: send every unfinished running task back to the tail
          if (is_rr && still_busy) begin
            busy[idx] <= 1'b0;
            count     <= count + 1'b1;
          end else begin
            busy[idx] <= still_busy;
          end
          idx <= pass_end ? '0 : idx + 1'b1;
        end
        mts_pkg::ST_DISPATCH: begin
          if (disp_go) begin
            if (take_head) begin
              busy[idx]   <= 1'b1;
              s_item[idx] <= head_take;
              s_wait[idx] <= head_wait;
              s_turn[idx] <= head_turn;
              count       <= count - 1'b1;
            end
            out_result.cpu_index      <= 3'(idx);
            out_result.running_valid  <= busy[idx] || take_head;
            out_result.running_id     <= take_head ? head_item.task_id :
                                         (busy[idx] ? s_item[idx].task_id : 8'd0);
            out_result.finished_valid <= f_valid[idx];
            out_result.finished_id    <= f_valid[idx] ? f_id[idx] : 8'd0;
            out_result.finished_wait  <= f_valid[idx] ? f_wait[idx] : 16'd0;
            out_result.finished_turnaround <= f_valid[idx] ? f_tat[idx] : 16'd0;
            out_result.queue_overflow <= overflow_seen;
            out_result.last           <= pass_end;
            idx <= idx + 1'b1;
          end
        end
        mts_pkg::ST_AGE: begin
          // drop requeued tasks beyond the queue depth
          count <= count_eff;
          for (int i = 0; i < NCPU; i++) begin
            if (CPU_W'(i) <= last_idx && busy[i]) begin
              if (s_item[i].rem != 16'd0) s_item[i].rem <= s_item[i].rem - 16'd1;
              if (s_turn[i] != '1) s_turn[i] <= s_turn[i] + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign in_item.ready = state == mts_pkg::ST_IDLE;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mts_pkg::ST_IDLE) |-> (count <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count above depth while idle");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_result.valid) |-> $past(state == mts_pkg::ST_DISPATCH))
    else $error("result raised outside dispatch pass");

  a_age_single: assert property (@(posedge clk) disable iff (rst)
    (state == mts_pkg::ST_AGE) |=> (state == mts_pkg::ST_IDLE))
    else $error("aging cycle did not return to idle");
`endif

endmodule

// ----- sim/tb_multiprocessor_task_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// tb_multiprocessor_task_scheduler_unit: self-checking bench of the scheduler
// Drives admit and tick transactions with random gaps across all scheduling
// modes and a range of processor counts, predicts every per-processor result and checks
// each result field by field, with random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_multiprocessor_task_scheduler_unit;

  localparam int NCPU       = 8;
  localparam int QDEPTH     = 64;
  localparam int CNT_LIMIT  = 65535;
  localparam int DRAIN_WAIT = 2 * NCPU + 8;

  typedef struct {
    logic        func;
    logic [7:0]  task_id;
    logic [15:0] burst;
    logic [7:0]  prio;
  } sched_item_t;

  typedef struct {
    bit [7:0]    id;
    int unsigned rem;
    bit [7:0]    rank;
    int unsigned waits;
    int unsigned turns;
    bit          started;
  } task_rec_t;

  typedef struct packed {
    logic [2:0]  cpu_index;
    logic        running_valid;
    logic [7:0]  running_id;
    logic        finished_valid;
    logic [7:0]  finished_id;
    logic [15:0] finished_wait;
    logic [15:0] finished_turnaround;
    logic        queue_overflow;
    logic        last;
  } cpu_result_t;

  logic       clk;
  logic       rst;
  logic       wr_en;
  logic       wr_index;
  logic [3:0] wr_data;

  mts_in_if  in_item ();
  mts_out_if out_result ();

  multiprocessor_task_scheduler_unit dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_item    (in_item),
    .out_result (out_result)
  );

  // scheduler mirror
  logic [1:0]  sched_mode;
  logic [3:0]  cpu_setting;
  task_rec_t   ready_list[$];
  bit          cpu_busy [NCPU];
  task_rec_t   cpu_task [NCPU];
  bit          overflow_flag;

  sched_item_t pending_items[$];
  cpu_result_t expected_results[$];
  int          error_count;
  int          send_gap;
  int          recv_stall;

  function automatic int unsigned sat_add(int unsigned v);
    return (v < CNT_LIMIT) ? v + 1 : v;
  endfunction

  function automatic void sched_admit(sched_item_t it);
    task_rec_t t;
    int        pos;
    int unsigned key;
    int unsigned new_key;
    if (ready_list.size() >= QDEPTH) begin
      overflow_flag = 1'b1;
      return;
    end
    pos = ready_list.size();
    if (sched_mode == mts_pkg::MODE_SJF || sched_mode == mts_pkg::MODE_PRIO) begin
      new_key = (sched_mode == mts_pkg::MODE_SJF) ? it.burst : it.prio;
      for (int i = 0; i < ready_list.size(); i++) begin
        key = (sched_mode == mts_pkg::MODE_SJF) ? ready_list[i].rem : ready_list[i].rank;
        if (key > new_key) begin
          pos = i;
          break;
        end
      end
    end
    t.id = it.task_id;
    t.rem = it.burst;
    t.rank = it.prio;
    t.waits = 0;
    t.turns = 0;
    t.started = 1'b0;
    ready_list.insert(pos, t);
  endfunction

  function automatic void sched_tick();
    int          n;
    int          k;
    bit          fin [NCPU];
    task_rec_t   done [NCPU];
    task_rec_t   seq[$];
    cpu_result_t r;
    int unsigned tat;
    n = (cpu_setting == 0) ? 1 : ((cpu_setting > NCPU) ? NCPU : cpu_setting);
    for (int i = 0; i < n; i++) begin
      fin[i] = 1'b0;
      if (cpu_busy[i] && cpu_task[i].rem == 0) begin
        fin[i] = 1'b1;
        done[i] = cpu_task[i];
        cpu_busy[i] = 1'b0;
      end
    end
    if (sched_mode == mts_pkg::MODE_RR) begin
      // requeued tasks follow the waiting ones; processors take from the front
      seq = ready_list;
      for (int i = 0; i < n; i++) begin
        if (cpu_busy[i]) begin
          seq.insert(seq.size(), cpu_task[i]);
          cpu_busy[i] = 1'b0;
        end
      end
      k = 0;
      for (int i = 0; i < n; i++) begin
        if (k < seq.size()) begin
          cpu_task[i] = seq[k];
          cpu_task[i].started = 1'b1;
          cpu_busy[i] = 1'b1;
          k++;
        end
      end
      ready_list.delete();
      while (k < seq.size() && ready_list.size() < QDEPTH) begin
        ready_list.insert(ready_list.size(), seq[k]);
        k++;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!cpu_busy[i] && ready_list.size() > 0) begin
          cpu_task[i] = ready_list.pop_front();
          cpu_busy[i] = 1'b1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      tat = fin[i] ? done[i].waits + done[i].turns : 0;
      r.cpu_index = i[2:0];
      r.running_valid = cpu_busy[i];
      r.running_id = cpu_busy[i] ? cpu_task[i].id : 8'd0;
      r.finished_valid = fin[i];
      r.finished_id = fin[i] ? done[i].id : 8'd0;
      r.finished_wait = fin[i] ? ((done[i].waits > CNT_LIMIT) ? 16'hFFFF : done[i].waits[15:0])
                               : 16'd0;
      r.finished_turnaround = (tat > CNT_LIMIT) ? 16'hFFFF : tat[15:0];
      r.queue_overflow = overflow_flag;
      r.last = (i == n - 1);
      expected_results.insert(expected_results.size(), r);
    end
    for (int i = 0; i < ready_list.size(); i++) begin
      if (sched_mode == mts_pkg::MODE_RR && ready_list[i].started)
        ready_list[i].turns = sat_add(ready_list[i].turns);
      else
        ready_list[i].waits = sat_add(ready_list[i].waits);
    end
    for (int i = 0; i < n; i++) begin
      if (cpu_busy[i]) begin
        if (cpu_task[i].rem > 0) cpu_task[i].rem--;
        cpu_task[i].turns = sat_add(cpu_task[i].turns);
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic push_admit(logic [7:0] id, logic [15:0] burst, logic [7:0] prio);
    sched_item_t it;
    it.func = mts_pkg::FUNC_ADMIT;
    it.task_id = id;
    it.burst = burst;
    it.prio = prio;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_ticks(int count);
    sched_item_t it;
    it.func = mts_pkg::FUNC_TICK;
    it.task_id = 8'($urandom);
    it.burst = 16'($urandom);
    it.prio = 8'($urandom);
    repeat (count) pending_items.insert(pending_items.size(), it);
  endtask

  task automatic write_reg(logic idx, logic [3:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    if (idx == mts_pkg::REG_MODE) sched_mode = data[1:0];
    else cpu_setting = data;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // hold until every transaction is taken and every result has come back
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_item.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic start_phase(logic [1:0] mode, logic [3:0] cpus);
    wait_drained();
    write_reg(mts_pkg::REG_MODE, {2'b00, mode});
    write_reg(mts_pkg::REG_CPUS, cpus);
  endtask

  task automatic push_random(int count, bit allow_long);
    logic [15:0] burst;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 45) begin
        burst = 16'($urandom_range(0, 6));
        if (allow_long && $urandom_range(0, 19) == 0) burst = 16'($urandom);
        push_admit(8'($urandom), burst, 8'($urandom));
      end else begin
        push_ticks(1);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    sched_item_t it;
    if (rst) begin
      in_item.valid <= 1'b0;
      in_item.func <= mts_pkg::FUNC_TICK;
      in_item.task_id <= 8'd0;
      in_item.burst_length <= 16'd0;
      in_item.task_priority <= 8'd0;
      send_gap <= 0;
    end else begin
      if (in_item.valid && in_item.ready) begin
        it.func = in_item.func;
        it.task_id = in_item.task_id;
        it.burst = in_item.burst_length;
        it.prio = in_item.task_priority;
        if (it.func == mts_pkg::FUNC_ADMIT) sched_admit(it);
        else sched_tick();
      end
      if (!in_item.valid || in_item.ready) begin
        if (send_gap > 0) begin
          in_item.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_item.valid <= 1'b1;
          in_item.func <= it.func;
          in_item.task_id <= it.task_id;
          in_item.burst_length <= it.burst;
          in_item.task_priority <= it.prio;
          send_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
        end else begin
          in_item.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    cpu_result_t got;
    cpu_result_t want;
    int          s;
    if (rst) begin
      out_result.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_result.valid && out_result.ready) begin
        got.cpu_index = out_result.cpu_index;
        got.running_valid = out_result.running_valid;
        got.running_id = out_result.running_id;
        got.finished_valid = out_result.finished_valid;
        got.finished_id = out_result.finished_id;
        got.finished_wait = out_result.finished_wait;
        got.finished_turnaround = out_result.finished_turnaround;
        got.queue_overflow = out_result.queue_overflow;
        got.last = out_result.last;
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (got.cpu_index !== want.cpu_index)
            report_mismatch($sformatf("cpu_index %0d exp %0d", got.cpu_index, want.cpu_index));
          if (got.running_valid !== want.running_valid)
            report_mismatch($sformatf("cpu %0d running_valid %0b exp %0b", want.cpu_index,
                                      got.running_valid, want.running_valid));
          if (got.running_id !== want.running_id)
            report_mismatch($sformatf("cpu %0d running_id %0d exp %0d", want.cpu_index,
                                      got.running_id, want.running_id));
          if (got.finished_valid !== want.finished_valid)
            report_mismatch($sformatf("cpu %0d finished_valid %0b exp %0b", want.cpu_index,
                                      got.finished_valid, want.finished_valid));
          if (got.finished_id !== want.finished_id)
            report_mismatch($sformatf("cpu %0d finished_id %0d exp %0d", want.cpu_index,
                                      got.finished_id, want.finished_id));
          if (got.finished_wait !== want.finished_wait)
            report_mismatch($sformatf("cpu %0d finished_wait %0d exp %0d", want.cpu_index,
                                      got.finished_wait, want.finished_wait));
          if (got.finished_turnaround !== want.finished_turnaround)
            report_mismatch($sformatf("cpu %0d finished_turnaround %0d exp %0d",
                                      want.cpu_index, got.finished_turnaround,
                                      want.finished_turnaround));
          if (got.queue_overflow !== want.queue_overflow)
            report_mismatch($sformatf("cpu %0d queue_overflow %0b exp %0b", want.cpu_index,
                                      got.queue_overflow, want.queue_overflow));
          if (got.last !== want.last)
            report_mismatch($sformatf("cpu %0d last %0b exp %0b", want.cpu_index,
                                      got.last, want.last));
        end
        s = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
        out_result.ready <= (s == 0);
        recv_stall <= s;
      end else if (!out_result.ready) begin
        if (recv_stall <= 1) out_result.ready <= 1'b1;
        else recv_stall <= recv_stall - 1;
      end
    end
  end

  initial begin
    logic [1:0] mode_list [8];
    logic [3:0] cpu_list  [8];
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = mts_pkg::REG_MODE;
    wr_data = 4'd0;
    error_count = 0;
    sched_mode = mts_pkg::MODE_FCFS;
    cpu_setting = 4'd1;
    overflow_flag = 1'b0;
    for (int i = 0; i < NCPU; i++) cpu_busy[i] = 1'b0;
    mode_list = '{mts_pkg::MODE_FCFS, mts_pkg::MODE_RR, mts_pkg::MODE_SJF, mts_pkg::MODE_PRIO,
                  mts_pkg::MODE_RR, mts_pkg::MODE_SJF, mts_pkg::MODE_FCFS, mts_pkg::MODE_PRIO};
    cpu_list  = '{4'd3, 4'd8, 4'd5, 4'd1, 4'd2, 4'd8, 4'd9, 4'd4};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // zero processor count acts as one; zero burst runs a tick and retires
    start_phase(mts_pkg::MODE_FCFS, 4'd0);
    push_admit(8'h00, 16'd0, 8'h00);
    push_admit(8'hFF, 16'd1, 8'hFF);
    push_ticks(4);

    // shortest job first with equal keys kept in arrival order
    start_phase(mts_pkg::MODE_SJF, 4'd2);
    push_admit(8'd10, 16'd5, 8'd3);
    push_admit(8'd11, 16'd2, 8'd3);
    push_admit(8'd12, 16'd2, 8'd1);
    push_admit(8'd13, 16'd5, 8'd0);
    push_ticks(5);

    // priority order; processor count above the maximum saturates
    start_phase(mts_pkg::MODE_PRIO, 4'd15);
    push_admit(8'd20, 16'd3, 8'd7);
    push_admit(8'd21, 16'd1, 8'd7);
    push_admit(8'd22, 16'd2, 8'd0);
    push_ticks(4);

    // round robin with one long task and an idle second processor
    start_phase(mts_pkg::MODE_RR, 4'd2);
    push_admit(8'd30, 16'hFFFF, 8'd9);
    push_admit(8'd31, 16'd2, 8'd9);
    push_admit(8'd32, 16'd0, 8'd9);
    push_ticks(5);

    for (int p = 0; p < 8; p++) begin
      start_phase(mode_list[p], cpu_list[p]);
      push_random(8, mode_list[p] == mts_pkg::MODE_RR);
    end

    // fill the queue past its depth, then let round robin churn it
    start_phase(mts_pkg::MODE_RR, 4'd8);
    for (int i = 0; i < QDEPTH + 6; i++) push_admit(8'($urandom), 16'($urandom_range(0, 2)),
                                                   8'($urandom));
    push_ticks(20);

    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
